/* hw/rtl/sll_pkg.sv */
// Package for the sorted linked-list engine.
// Holds the request modes, result status codes, controller states and the
// command and status bundles between the controller and the datapath.
package sll_pkg;

   localparam int MODE_BITS     = 2;
   localparam int STATUS_BITS   = 2;
   localparam int KEY_BITS      = 32;
   localparam int SLOT_BITS     = 6;
   localparam int COUNT_BITS    = 7;
   localparam int RSP_DATA_BITS = 16;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - SLOT_BITS - COUNT_BITS;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_DUP     = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_WALK,
      S_DECIDE,
      S_INS_RD,
      S_INS_W1,
      S_INS_W2,
      S_DEL_W1,
      S_DEL_W2,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       latch_req;
      logic       rebuild;
      logic       walk_start;
      logic       walk_step;
      logic       capture;
      logic       ins_read;
      logic       ins_w1;
      logic       ins_w2;
      logic       del_w1;
      logic       del_w2;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_use_slot;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     free_empty;
      logic     walk_more;
      logic     found;
      logic     rsp_busy;
   } dp_status_type;

endpackage

/* hw/rtl/sorted_linked_list_engine.sv */
// Top level of the sorted linked-list engine.
// Joins sll_ctrl and sll_dpath and packs the stream channels; uses sll_pkg.
//
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: mode; tdata: key
// rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: slot, entry count
//
// A search, a delete or an insert walks the list past the keys below its key;
// the walk reads one link per cycle. An insert then reads the free head and
// writes its links; a delete rewrites its links.
// A clear or a refused insert on a full store skips the walk.
// Reset needs no clearing pass; a clear request likewise.
// A finished result waits in the output register while the next request is
// taken; the engine holds its result state only while that register is full.
module sorted_linked_list_engine #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sll_pkg::KEY_BITS-1:0]        req_tdata,  // [31:0] key
   input  logic [sll_pkg::MODE_BITS-1:0]       req_tuser,  // [1:0] mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sll_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // [5:0] slot, [12:6] entry count
   output logic [sll_pkg::STATUS_BITS-1:0]     rsp_tuser   // [1:0] status
);
   import sll_pkg::*;

   cmd_type               cmd;
   dp_status_type         sts;
   logic [SLOT_BITS-1:0]  rsp_slot;
   logic [COUNT_BITS-1:0] rsp_count;

   sll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sll_dpath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_mode   (req_tuser),
      .req_key    (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_slot   (rsp_slot),
      .rsp_count  (rsp_count),
      .cmd        (cmd),
      .sts        (sts)
   );

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, rsp_count, rsp_slot};

   // The engine takes one request at a time.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   // A failed request never reports a slot.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status_type'(rsp_tuser) != ST_OK) |-> rsp_slot == '0)
      else $error("slot reported on a failed request");

   // At most one link update or walk step per cycle on the link memory.
   a_link_port: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.walk_step, cmd.ins_w1, cmd.ins_w2, cmd.del_w1, cmd.del_w2}))
      else $error("link memory commands overlap");

endmodule

/* hw/rtl/sll_ctrl.sv */
// Controller state machine of the sorted linked-list engine.
// Sequences the list walk and the link updates; depends on sll_pkg.
module sll_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sll_pkg::dp_status_type sts,
   output sll_pkg::cmd_type       cmd
);
   import sll_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       use_slot_ff, use_slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff   <= status_in;
      use_slot_ff <= use_slot_in;
   end

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      use_slot_in = use_slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.mode == MODE_CLEAR) begin
               status_in   = ST_OK;
               use_slot_in = 1'b0;
               state_in    = S_RESP;
            end else if (sts.mode == MODE_INSERT && sts.free_empty) begin
               status_in   = ST_FULL;
               use_slot_in = 1'b0;
               state_in    = S_RESP;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (!sts.walk_more) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.mode == MODE_INSERT) begin
               status_in   = sts.found ? ST_DUP : ST_OK;
               use_slot_in = !sts.found;
               state_in    = sts.found ? S_RESP : S_INS_RD;
            end else begin
               status_in   = sts.found ? ST_OK : ST_MISSING;
               use_slot_in = sts.found;
               state_in    = (sts.found && sts.mode == MODE_DELETE) ? S_DEL_W1 : S_RESP;
            end
         end
         S_INS_RD: state_in = S_INS_W1;
         S_INS_W1: state_in = S_INS_W2;
         S_INS_W2: state_in = S_RESP;
         S_DEL_W1: state_in = S_DEL_W2;
         S_DEL_W2: state_in = S_RESP;
         S_RESP: begin
            if (!sts.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.rsp_status   = status_ff;
      cmd.rsp_use_slot = use_slot_ff;
      req_tready       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready    = 1'b1;
            cmd.latch_req = req_tvalid;
         end
         S_DISPATCH: begin
            if (sts.mode == MODE_CLEAR) begin
               cmd.rebuild = 1'b1;
            end else if (!(sts.mode == MODE_INSERT && sts.free_empty)) begin
               cmd.walk_start = 1'b1;
            end
         end
         S_WALK: begin
            cmd.walk_step = sts.walk_more;
            cmd.capture   = !sts.walk_more;
         end
         S_DECIDE: begin
         end
         S_INS_RD: cmd.ins_read = 1'b1;
         S_INS_W1: cmd.ins_w1   = 1'b1;
         S_INS_W2: cmd.ins_w2   = 1'b1;
         S_DEL_W1: cmd.del_w1   = 1'b1;
         S_DEL_W2: cmd.del_w2   = 1'b1;
         S_RESP:   cmd.rsp_load = !sts.rsp_busy;
         default: begin
         end
      endcase
   end

endmodule

/* hw/rtl/sll_dpath.sv */
// Datapath of the sorted linked-list engine: key and link memories, list
// pointers, walk registers and the result register; depends on sll_pkg.
module sll_dpath #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sll_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [sll_pkg::KEY_BITS-1:0]        req_key,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic [sll_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [sll_pkg::SLOT_BITS-1:0]       rsp_slot,
   output logic [sll_pkg::COUNT_BITS-1:0]      rsp_count,
   input  sll_pkg::cmd_type                    cmd,
   output sll_pkg::dp_status_type              sts
);
   import sll_pkg::*;

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LW       = $clog2(CAPACITY + 1);
   localparam int EFF      = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
   localparam int SLOT_PAD = (IDX_W > SLOT_BITS) ? IDX_W : SLOT_BITS;
   localparam int CNT_PAD  = (LW > COUNT_BITS) ? LW : COUNT_BITS;
   localparam logic [LW-1:0] NIL  = LW'(CAPACITY);
   localparam logic [LW-1:0] LAST = LW'(CAPACITY - 1);

   logic [EFF-1:0]   key_mem  [CAPACITY];
   logic [LW-1:0]    link_mem [CAPACITY];

   mode_type         mode_ff, mode_in;
   logic [EFF-1:0]   key_ff, key_in;
   logic [LW-1:0]    list_head_ff, list_head_in;
   logic [LW-1:0]    free_head_ff, free_head_in;
   logic [LW-1:0]    count_ff, count_in;
   logic [LW-1:0]    fill_ff, fill_in;
   logic [LW-1:0]    c_ff, c_in;
   logic [LW-1:0]    p_ff, p_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [LW-1:0]    nxt_ff, nxt_in;
   logic             found_ff, found_in;
   logic [LW-1:0]    rd_addr_ff;
   logic [EFF-1:0]   key_rd_ff;
   logic [LW-1:0]    link_rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic             link_re, key_re, link_we;
   logic [LW-1:0]    link_raddr, link_wdata, link_next, link_seq;
   logic [IDX_W-1:0] link_waddr;
   logic             c_valid, p_valid;
   logic [SLOT_PAD-1:0] slot_wide;
   logic [CNT_PAD-1:0]  count_wide;

   assign c_valid = c_ff < NIL;
   assign p_valid = p_ff < NIL;

   // Slots at or above the fill mark were never taken since the last rebuild,
   // so their link is taken as the next slot in sequence (NIL after the last), not read from memory.
   assign link_seq  = (rd_addr_ff == LAST) ? NIL : rd_addr_ff + LW'(1);
   assign link_next = (rd_addr_ff >= fill_ff) ? link_seq : link_rd_ff;

   always_comb begin
      link_re = cmd.walk_start | cmd.walk_step | cmd.ins_read;
      key_re  = cmd.walk_start | cmd.walk_step;
      if (cmd.walk_start) begin
         link_raddr = list_head_ff;
      end else if (cmd.walk_step) begin
         link_raddr = link_next;
      end else begin
         link_raddr = free_head_ff;
      end
   end

   always_comb begin
      link_we    = 1'b0;
      link_waddr = free_head_ff[IDX_W-1:0];
      link_wdata = c_ff;
      priority if (cmd.ins_w1) begin
         link_we = 1'b1;
      end else if (cmd.ins_w2) begin
         link_we    = p_valid;
         link_waddr = p_ff[IDX_W-1:0];
         link_wdata = LW'(slot_ff);
      end else if (cmd.del_w1) begin
         link_we    = p_valid;
         link_waddr = p_ff[IDX_W-1:0];
         link_wdata = nxt_ff;
      end else if (cmd.del_w2) begin
         link_we    = 1'b1;
         link_waddr = c_ff[IDX_W-1:0];
         link_wdata = free_head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr[IDX_W-1:0]];
         rd_addr_ff <= link_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_w1) begin
         key_mem[free_head_ff[IDX_W-1:0]] <= key_ff;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[link_raddr[IDX_W-1:0]];
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      key_in        = key_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      c_in          = c_ff;
      p_in          = p_ff;
      slot_in       = slot_ff;
      nxt_in        = nxt_ff;
      found_in      = found_ff;
      slot_wide     = SLOT_PAD'(slot_ff);
      count_wide    = CNT_PAD'(count_ff);
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;

      if (cmd.latch_req) begin
         mode_in = mode_type'(req_mode);
         // Flipping the sign bit makes unsigned order match signed order.
         key_in  = {~req_key[EFF-1], req_key[EFF-2:0]};
      end
      if (cmd.rebuild) begin
         list_head_in = NIL;
         free_head_in = '0;
         count_in     = '0;
         fill_in      = '0;
      end
      if (cmd.walk_start) begin
         c_in = list_head_ff;
         p_in = NIL;
      end
      if (cmd.walk_step) begin
         c_in = link_next;
         p_in = c_ff;
      end
      if (cmd.capture) begin
         slot_in  = c_ff[IDX_W-1:0];
         nxt_in   = link_next;
         found_in = c_valid && (key_rd_ff == key_ff);
      end
      if (cmd.ins_w1) begin
         free_head_in = link_next;
         slot_in      = free_head_ff[IDX_W-1:0];
         if (free_head_ff == fill_ff) begin
            fill_in = fill_ff + LW'(1);
         end
      end
      if (cmd.ins_w2) begin
         if (!p_valid) begin
            list_head_in = LW'(slot_ff);
         end
         count_in = count_ff + LW'(1);
      end
      if (cmd.del_w1 && !p_valid) begin
         list_head_in = nxt_ff;
      end
      if (cmd.del_w2) begin
         free_head_in = c_ff;
         if (count_ff != '0) begin
            count_in = count_ff - LW'(1);
         end
      end
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_slot_in   = cmd.rsp_use_slot ? slot_wide[SLOT_BITS-1:0] : '0;
         rsp_count_in  = count_wide[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_head_ff <= NIL;
         free_head_ff <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      c_ff          <= c_in;
      p_ff          <= p_in;
      slot_ff       <= slot_in;
      nxt_ff        <= nxt_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign sts.mode       = mode_ff;
   assign sts.free_empty = (free_head_ff == NIL);
   assign sts.walk_more  = c_valid && (key_rd_ff < key_ff);
   assign sts.found      = found_ff;
   assign sts.rsp_busy   = rsp_valid_ff & ~rsp_tready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_count  = rsp_count_ff;

endmodule
